[design/afcc_pkg.sv]
// Package for the averaged fan curve controller: opcodes, word layout,
// curve write bundle and curve reset tables. No dependencies.
package afcc_pkg;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_OVERRIDE = 2'd1,
        OP_CURVE_WR = 2'd2
    } opcode_t;

    localparam int TEMP_W  = 16;
    localparam int TIME_W  = 32;
    localparam int SPEED_W = 16;
    localparam int INDEX_W = 3;

    // Input word layout, lowest bit first
    localparam int TEMP_LSB     = 0;
    localparam int NOW_LSB      = TEMP_LSB + TEMP_W;
    localparam int OV_SPEED_LSB = NOW_LSB + TIME_W;
    localparam int OV_DUR_LSB   = OV_SPEED_LSB + SPEED_W;
    localparam int INDEX_LSB    = OV_DUR_LSB + TIME_W;
    localparam int THR_LSB      = INDEX_LSB + INDEX_W;
    localparam int CSPEED_LSB   = THR_LSB + TEMP_W;
    localparam int IN_BITS      = CSPEED_LSB + SPEED_W;
    localparam int S_TDATA_W    = ((IN_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W    = SPEED_W + TEMP_W;

    localparam int MAX_ENTRIES = 16;

    localparam logic [TEMP_W-1:0] CURVE_RST_THRESHOLD [MAX_ENTRIES] = '{
        16'd0, 16'd24000, 16'd24500, 16'd25000, 16'd25500, 16'd26000, 16'd27000,
        16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
        16'hFFFF, 16'hFFFF
    };

    localparam logic [SPEED_W-1:0] CURVE_RST_SPEED [MAX_ENTRIES] = '{
        16'd0, 16'd1000, 16'd1500, 16'd2000, 16'd2500, 16'd3000, 16'd4000,
        16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0
    };

    typedef struct packed {
        logic               en;
        logic [INDEX_W-1:0] index;
        logic [TEMP_W-1:0]  threshold;
        logic [SPEED_W-1:0] speed;
    } curve_wr_t;

endpackage

[design/afcc_curve.sv]
// Fan curve table: threshold/speed entries with write port and lookup.
// Depends on afcc_pkg.
module afcc_curve
    import afcc_pkg::*;
#(
    parameter int CURVE_ENTRIES = 7
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  curve_wr_t          wr,
    input  logic [TEMP_W-1:0]  avg,
    output logic [SPEED_W-1:0] speed
);

    logic [TEMP_W-1:0]  thr_reg [CURVE_ENTRIES];
    logic [SPEED_W-1:0] spd_reg [CURVE_ENTRIES];

    // one write port; an index past the table matches no entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CURVE_ENTRIES; i++)
            begin
                thr_reg[i] <= CURVE_RST_THRESHOLD[i];
                spd_reg[i] <= CURVE_RST_SPEED[i];
            end
        end
        else if (wr.en)
        begin
            for (int i = 0; i < CURVE_ENTRIES; i++)
            begin
                if ({2'b00, wr.index} == 5'(i))
                begin
                    thr_reg[i] <= wr.threshold;
                    spd_reg[i] <= wr.speed;
                end
            end
        end
    end

    // last entry strictly below the average wins; none -> 0
    always_comb
    begin
        speed = '0;
        for (int i = 0; i < CURVE_ENTRIES; i++)
        begin
            if (avg > thr_reg[i])
                speed = spd_reg[i];
        end
    end

endmodule

[design/averaged_fan_curve_controller_top.sv]
// Top level of the averaged fan curve controller: stream ports, input
// register, sample ring, override timer, result register. Uses afcc_pkg, afcc_curve.
//
// Fan target controller. Each input word carries an opcode on s_tuser: a tick
// (0) writes the temperature sample into a ring of SAMPLE_COUNT samples and
// looks the floor mean up on the fan curve, giving one result word; while an
// override runs (current_time < end time, unsigned) a tick instead returns the
// forced speed and the mean of the unchanged ring with override_active set.
// Opcode 1 starts an override (end = current_time + duration, mod 2^32),
// opcode 2 replaces one curve entry (indexes past CURVE_ENTRIES are dropped),
// opcode 3 does nothing. Only ticks produce a result. Throughput is one word
// per cycle unless a tick waits on a full result register that is not taken;
// the accepting edge loads the input register, and a later edge, once the
// result register is free, loads the mean/curve result into it. The ring sum
// is kept as a running total, so the mean is one subtract/add and a
// constant reciprocal multiply. s_tready falls only when both registers are
// full and the result is not being taken.
module averaged_fan_curve_controller_top
    import afcc_pkg::*;
#(
    parameter int SAMPLE_COUNT  = 4,
    parameter int CURVE_ENTRIES = 7
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // temperature, current_time, override_fan_speed, override_duration,
    // curve_index, curve_threshold, curve_speed, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // opcode
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // fan_target, averaged_temperature
    output logic [M_TDATA_W-1:0] m_tdata,
    // override_active
    output logic                 m_tuser
);

    localparam int SHIFT_L = $clog2(SAMPLE_COUNT);
    localparam int SUM_W   = TEMP_W + SHIFT_L;
    localparam int POS_W   = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
    localparam int MUL_SH  = SUM_W + SHIFT_L;
    localparam int PROD_W  = 2 * SUM_W + 1;
    // ceil(2^MUL_SH / N): exact floor division for any sum below 2^SUM_W
    localparam logic [SUM_W:0] RECIP = (SUM_W + 1)'(
        ((64'd1 << MUL_SH) + 64'(SAMPLE_COUNT) - 64'd1) / 64'(SAMPLE_COUNT));

    // input register
    logic                 s1_valid_reg, s1_valid_next;
    logic [1:0]           s1_opcode_reg;
    logic [S_TDATA_W-1:0] s1_tdata_reg;

    // state
    logic [TEMP_W-1:0]  ring_reg [SAMPLE_COUNT];
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [SPEED_W-1:0] forced_reg;
    logic [TIME_W-1:0]  end_time_reg;

    // result register
    logic                 out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic                 out_active_reg;

    logic s_accept, out_free, s1_is_tick, s1_go, ovr_running, tick_sample;

    logic [TEMP_W-1:0]  f_temp;
    logic [TIME_W-1:0]  f_now, f_dur;
    logic [SPEED_W-1:0] f_ov_speed, f_cspeed, curve_speed, fan_target;
    logic [INDEX_W-1:0] f_index;
    logic [TEMP_W-1:0]  f_thr, mean;
    logic [SUM_W-1:0]   sum_sel;
    logic [PROD_W-1:0]  prod;
    curve_wr_t          curve_wr;

    assign f_temp     = s1_tdata_reg[TEMP_LSB +: TEMP_W];
    assign f_now      = s1_tdata_reg[NOW_LSB +: TIME_W];
    assign f_ov_speed = s1_tdata_reg[OV_SPEED_LSB +: SPEED_W];
    assign f_dur      = s1_tdata_reg[OV_DUR_LSB +: TIME_W];
    assign f_index    = s1_tdata_reg[INDEX_LSB +: INDEX_W];
    assign f_thr      = s1_tdata_reg[THR_LSB +: TEMP_W];
    assign f_cspeed   = s1_tdata_reg[CSPEED_LSB +: SPEED_W];

    // handshake
    assign s1_is_tick = (s1_opcode_reg == OP_TICK);
    assign out_free   = !out_valid_reg || m_tready;
    assign s1_go      = s1_valid_reg && (!s1_is_tick || out_free);
    assign s_tready   = !s1_valid_reg || s1_go;
    assign s_accept   = s_tvalid && s_tready;

    assign ovr_running = (f_now < end_time_reg);
    assign tick_sample = s1_go && s1_is_tick && !ovr_running;

    // running sum of the ring after this tick
    assign sum_next = sum_reg - SUM_W'(ring_reg[pos_reg]) + SUM_W'(f_temp);
    assign sum_sel  = ovr_running ? sum_reg : sum_next;
    assign prod     = PROD_W'(sum_sel) * PROD_W'(RECIP);
    assign mean     = TEMP_W'(prod >> MUL_SH);

    assign pos_next = (pos_reg == POS_W'(SAMPLE_COUNT - 1)) ? '0 : pos_reg + 1'b1;

    assign curve_wr.en        = s1_go && (s1_opcode_reg == OP_CURVE_WR);
    assign curve_wr.index     = f_index;
    assign curve_wr.threshold = f_thr;
    assign curve_wr.speed     = f_cspeed;

    afcc_curve #(
        .CURVE_ENTRIES (CURVE_ENTRIES)
    ) u_curve (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (curve_wr),
        .avg   (mean),
        .speed (curve_speed)
    );

    assign fan_target = ovr_running ? forced_reg : curve_speed;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s_accept)
            s1_valid_next = 1'b1;
        else if (s1_go)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_go && s1_is_tick)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_opcode_reg <= s_tuser;
            s1_tdata_reg  <= s_tdata;
        end
        if (s1_go && s1_is_tick)
        begin
            out_data_reg   <= {mean, fan_target};
            out_active_reg <= ovr_running;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            sum_reg      <= '0;
            forced_reg   <= '0;
            end_time_reg <= '0;
            for (int i = 0; i < SAMPLE_COUNT; i++)
                ring_reg[i] <= '0;
        end
        else
        begin
            if (tick_sample)
            begin
                ring_reg[pos_reg] <= f_temp;
                pos_reg           <= pos_next;
                sum_reg           <= sum_next;
            end
            if (s1_go && (s1_opcode_reg == OP_OVERRIDE))
            begin
                forced_reg   <= f_ov_speed;
                end_time_reg <= f_now + f_dur;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_active_reg;

`ifndef ASSERT_OFF
    a_result_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_go && s1_is_tick))
        else $error("result word without a processed tick");

    a_pos_advances: assert property (@(posedge clk) disable iff (!rst_n)
        tick_sample |=> (SAMPLE_COUNT == 1) || (pos_reg != $past(pos_reg)))
        else $error("ring position did not advance on a sampled tick");

    a_pos_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !tick_sample |=> $stable(pos_reg) && $stable(sum_reg))
        else $error("ring changed without a sampled tick");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_go |=> s1_valid_reg && $stable(s1_tdata_reg))
        else $error("stalled input register was overwritten");
`endif

endmodule

[dv/tb.sv]
// Self-checking testbench for averaged_fan_curve_controller_top: stream driver and
// monitor around a cycle-free predictor of ring average, curve lookup and override.
// Depends on design/afcc_pkg.sv and design/averaged_fan_curve_controller_top.sv.
`timescale 1ns / 100ps

module tb;
    import afcc_pkg::*;

    localparam int RING_N = 4;
    localparam int CURVE_N = 7;
    localparam int PAD_W = S_TDATA_W - IN_BITS;
    localparam logic [1:0] OP_UNUSED = 2'd3;    // opcode with no effect
    localparam int WORDS_PER_PHASE = 250;

    // s_tdata layout, MSB first in the struct so temperature lands in the low bits
    typedef struct packed {
        logic [PAD_W-1:0]   pad;
        logic [SPEED_W-1:0] curve_speed;
        logic [TEMP_W-1:0]  curve_threshold;
        logic [INDEX_W-1:0] curve_index;
        logic [TIME_W-1:0]  ov_duration;
        logic [SPEED_W-1:0] ov_speed;
        logic [TIME_W-1:0]  now;
        logic [TEMP_W-1:0]  temperature;
    } fan_fields_t;

    typedef struct {
        logic [1:0]  op;
        fan_fields_t f;
    } fan_word_t;

    typedef struct {
        logic [SPEED_W-1:0] fan_target;
        logic [TEMP_W-1:0]  avg_temp;
        logic               override_on;
    } fan_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [1:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    averaged_fan_curve_controller_top u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // Predicted block state, kept in step with every accepted word
    logic [TEMP_W-1:0]  ring_samples [RING_N];
    logic [1:0]         ring_pos;
    logic [TEMP_W-1:0]  curve_thr [CURVE_N];
    logic [SPEED_W-1:0] curve_spd [CURVE_N];
    logic [SPEED_W-1:0] forced_speed;
    logic [TIME_W-1:0]  ov_end_time;

    fan_word_t   pending_words [$];     // words still to be offered
    fan_result_t expected_results [$];  // predicted results, oldest first
    fan_word_t   offered_word;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_rx = 1'b0;               // long receiver hold-off for back-pressure

    int errors = 0;
    int words_accepted = 0;
    int results_seen = 0;
    int ticks_sent = 0;
    int overrides_hit = 0;
    int curve_writes = 0;
    int input_stalls = 0;
    logic [TIME_W-1:0] sim_now = '0;    // running time base for random words

    // Predictor: applies one accepted word to the model state, queues a result on ticks
    task automatic fan_curve_predict(input fan_word_t w);
        fan_result_t r;
        logic [TEMP_W+1:0] ring_sum;
        r.fan_target = '0;
        r.override_on = 1'b0;
        case (w.op)
            OP_TICK:
            begin
                if (w.f.now < ov_end_time)
                begin
                    // override running: no sample, forced speed
                    r.override_on = 1'b1;
                    r.fan_target = forced_speed;
                    overrides_hit++;
                end
                else
                begin
                    ring_samples[ring_pos] = w.f.temperature;
                    ring_pos = ring_pos + 2'd1;
                end
                ring_sum = (TEMP_W+2)'(ring_samples[0]) + ring_samples[1]
                         + ring_samples[2] + ring_samples[3];
                r.avg_temp = ring_sum[TEMP_W+1:2];
                if (!r.override_on)
                begin
                    // last entry strictly below the mean wins, none gives zero
                    for (int i = 0; i < CURVE_N; i++)
                        if (r.avg_temp > curve_thr[i])
                            r.fan_target = curve_spd[i];
                end
                expected_results.push_back(r);
                ticks_sent++;
            end
            OP_OVERRIDE:
            begin
                forced_speed = w.f.ov_speed;
                ov_end_time = w.f.now + w.f.ov_duration;   // wraps mod 2^32
            end
            OP_CURVE_WR:
            begin
                if (w.f.curve_index < CURVE_N)
                begin
                    curve_thr[w.f.curve_index] = w.f.curve_threshold;
                    curve_spd[w.f.curve_index] = w.f.curve_speed;
                end
                curve_writes++;
            end
            default: ;
        endcase
    endtask

    // Word with every field random; callers overwrite the ones that matter
    function automatic fan_word_t random_fan_word(input logic [1:0] op);
        fan_word_t w;
        w.op = op;
        w.f.pad = '0;
        w.f.curve_speed = SPEED_W'($urandom);
        w.f.curve_threshold = TEMP_W'($urandom);
        w.f.curve_index = INDEX_W'($urandom);
        w.f.ov_duration = $urandom;
        w.f.ov_speed = SPEED_W'($urandom);
        w.f.now = $urandom;
        w.f.temperature = TEMP_W'($urandom);
        return w;
    endfunction

    task automatic queue_tick(input logic [TEMP_W-1:0] temp, input logic [TIME_W-1:0] now);
        fan_word_t w;
        w = random_fan_word(OP_TICK);
        w.f.temperature = temp;
        w.f.now = now;
        pending_words.push_back(w);
    endtask

    task automatic queue_override(input logic [TIME_W-1:0] now,
                                  input logic [SPEED_W-1:0] speed,
                                  input logic [TIME_W-1:0] dur);
        fan_word_t w;
        w = random_fan_word(OP_OVERRIDE);
        w.f.now = now;
        w.f.ov_speed = speed;
        w.f.ov_duration = dur;
        pending_words.push_back(w);
    endtask

    task automatic queue_curve(input logic [INDEX_W-1:0] idx,
                               input logic [TEMP_W-1:0] thr,
                               input logic [SPEED_W-1:0] spd);
        fan_word_t w;
        w = random_fan_word(OP_CURVE_WR);
        w.f.curve_index = idx;
        w.f.curve_threshold = thr;
        w.f.curve_speed = spd;
        pending_words.push_back(w);
    endtask

    // Random traffic shaped around a slowly advancing clock so overrides start and expire
    task automatic queue_random_words(input int count);
        int pick;
        int k;
        for (k = 0; k < count; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                if ($urandom_range(99) < 2)
                    sim_now = $urandom;                 // time jump, hits high bits
                else
                    sim_now = sim_now + $urandom_range(3);
                if ($urandom_range(99) < 80)
                    queue_tick(TEMP_W'($urandom_range(28500, 23000)), sim_now);
                else
                    queue_tick(TEMP_W'($urandom), sim_now);
            end
            else if (pick < 80)
            begin
                pick = $urandom_range(99);
                queue_override(sim_now, SPEED_W'($urandom),
                               pick < 85 ? TIME_W'($urandom_range(24))
                                         : (pick < 95 ? TIME_W'($urandom) : '0));
            end
            else if (pick < 94)
            begin
                pick = $urandom_range(99);
                queue_curve(INDEX_W'($urandom_range(7)),
                            pick < 15 ? 16'hFFFF
                                      : (pick < 75 ? TEMP_W'($urandom_range(28500, 23000))
                                                   : TEMP_W'($urandom)),
                            SPEED_W'($urandom));
            end
            else
            begin
                pending_words.push_back(random_fan_word(OP_UNUSED));
            end
        end
    endtask

    // Driver: predicts each word at its handshake, then offers the next or idles
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
        end
        else
        begin
            if (s_tvalid && !s_tready)
                input_stalls++;
            if (s_tvalid && s_tready)
            begin
                fan_curve_predict(offered_word);
                words_accepted++;
            end
            // a word still waiting for s_tready stays put
            if (!(s_tvalid && !s_tready))
            begin
                if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    offered_word = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= offered_word.f;
                    s_tuser <= offered_word.op;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result word against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t ERROR result with nothing expected: target %0d avg %0d ov %0b",
                             $time, m_tdata[SPEED_W-1:0], m_tdata[M_TDATA_W-1:SPEED_W], m_tuser);
                end
                else
                begin
                    fan_result_t e;
                    e = expected_results.pop_front();
                    if (m_tdata[SPEED_W-1:0] !== e.fan_target)
                    begin
                        errors++;
                        $display("%0t ERROR fan_target expected %0d actual %0d",
                                 $time, e.fan_target, m_tdata[SPEED_W-1:0]);
                    end
                    if (m_tdata[M_TDATA_W-1:SPEED_W] !== e.avg_temp)
                    begin
                        errors++;
                        $display("%0t ERROR averaged_temperature expected %0d actual %0d",
                                 $time, e.avg_temp, m_tdata[M_TDATA_W-1:SPEED_W]);
                    end
                    if (m_tuser !== e.override_on)
                    begin
                        errors++;
                        $display("%0t ERROR override_active expected %0b actual %0b",
                                 $time, e.override_on, m_tuser);
                    end
                end
            end
            if (hold_rx)
                m_tready <= 1'b0;
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Wait at falling edges until every queued word went in and every result came out
    task automatic drain_all();
        while (pending_words.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(negedge clk);
    endtask

    initial
    begin
        int guard;
        ring_pos = '0;
        forced_speed = '0;
        ov_end_time = '0;
        for (int i = 0; i < RING_N; i++)
            ring_samples[i] = '0;
        for (int i = 0; i < CURVE_N; i++)
        begin
            curve_thr[i] = CURVE_RST_THRESHOLD[i];
            curve_spd[i] = CURVE_RST_SPEED[i];
        end

        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Directed: zero mean misses every threshold, full-scale samples
        queue_tick(16'd0, 32'd0);
        queue_tick(16'hFFFF, 32'd1);
        queue_tick(16'hFFFF, 32'd2);
        queue_tick(16'hFFFF, 32'd3);
        queue_tick(16'hFFFF, 32'd4);
        queue_tick(16'd0, 32'd5);
        // ignored index, disabled entries
        queue_curve(3'd7, 16'd0, 16'hFFFF);
        queue_curve(3'd0, 16'hFFFF, 16'd7);
        queue_curve(3'd6, 16'hFFFF, 16'hFFFF);
        queue_tick(16'd25200, 32'd6);
        // override: running, exactly at end, just before end
        queue_override(32'd100, 16'hFFFF, 32'd50);
        queue_tick(16'd30000, 32'd120);
        queue_tick(16'd26000, 32'd150);
        queue_tick(16'd1234, 32'd149);
        // end time wraps past 2^32
        queue_override(32'hFFFF_FFF0, 16'd777, 32'h20);
        queue_tick(16'd24100, 32'd5);
        queue_tick(16'd24100, 32'hFFFF_FFF8);
        // zero duration cancels, largest duration
        queue_override(32'd200, 16'd9, 32'd0);
        queue_tick(16'd27500, 32'd200);
        queue_override(32'd0, 16'd4321, 32'hFFFF_FFFF);
        queue_tick(16'd27500, 32'hFFFF_FFFE);
        queue_tick(16'd27500, 32'hFFFF_FFFF);
        pending_words.push_back(random_fan_word(OP_UNUSED));
        queue_curve(3'd0, CURVE_RST_THRESHOLD[0], CURVE_RST_SPEED[0]);
        queue_curve(3'd6, CURVE_RST_THRESHOLD[6], CURVE_RST_SPEED[6]);
        drain_all();

        // Random phases: no idling, sender gaps, receiver stalls, both
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = (phase == 1) ? 47 : ((phase == 3) ? 30 : 0);
            recv_stall_pct = (phase == 2) ? 47 : ((phase == 3) ? 30 : 0);
            queue_random_words(WORDS_PER_PHASE);
            drain_all();
        end

        // Back-pressure: sender streams ticks while the receiver holds off
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int k = 0; k < 60; k++)
        begin
            sim_now = sim_now + 1;
            queue_tick(TEMP_W'($urandom_range(28500, 23000)), sim_now);
        end
        hold_rx = 1'b1;
        repeat (150) @(negedge clk);
        hold_rx = 1'b0;

        queue_random_words(40);
        while (pending_words.size() > 0 || s_tvalid)
            @(negedge clk);
        guard = 0;
        while (expected_results.size() > 0 && guard < 20000)
        begin
            guard++;
            @(negedge clk);
        end
        repeat (20) @(negedge clk);   // catch stray results after the last one
        if (expected_results.size() > 0)
        begin
            errors += expected_results.size();
            $display("%0t ERROR %0d expected results never arrived",
                     $time, expected_results.size());
        end

        $display("Covered %0d words: %0d ticks (%0d under override), %0d curve writes",
                 words_accepted, ticks_sent, overrides_hit, curve_writes);
        $display("Checked %0d results, %0d input stall cycles, %0d errors",
                 results_seen, input_stalls, errors);
        if (errors == 0)
            $display("PASS averaged_fan_curve_controller_top");
        else
            $display("FAIL averaged_fan_curve_controller_top");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("%0t ERROR timeout", $time);
        $display("FAIL averaged_fan_curve_controller_top");
        $finish;
    end

endmodule
